/* rtl/pve_pkg.sv */
package pve_pkg;

  localparam int PI_Q       = 3294199;
  localparam int TWO_PI_Q   = 6588398;
  localparam int RATE_RESET = 100;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic signed [MUL_B_W-1:0] COEF_OLD = 17'sd45875;
  localparam logic signed [MUL_B_W-1:0] COEF_RAW = 17'sd19661;

  localparam logic signed [PROD_W-1:0] FILT_ROUND = 51'sd32768;
  localparam logic signed [PROD_W-1:0] YAW_ROUND  = 51'sd8;
  localparam int FILT_SHIFT = 16;
  localparam int YAW_SHIFT  = 4;

  localparam logic signed [MUL_A_W-1:0] DIFF_MAX = 34'sd4294967296;
  localparam logic signed [MUL_A_W-1:0] DIFF_MIN = -34'sd4294967296;

  localparam logic [1:0] CH_X   = 2'd0;
  localparam logic [1:0] CH_Y   = 2'd1;
  localparam logic [1:0] CH_YAW = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WRAP = 7'b0000010,
    S_MRAW = 7'b0000100,
    S_MOLD = 7'b0001000,
    S_MNEW = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sd2147483647);
    lo = -PROD_W'(64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

/* rtl/pose_velocity_estimator.sv */
// pose velocity estimator
// input channel: pos_x_i, pos_y_i, heading_i with in_valid_i / in_stall_o; one item
// per pose sample. output channel: vel_x_o, vel_y_o, yaw_rate_o with out_valid_o /
// out_stall_i; exactly one result item per input item, in order.
// sample_rate_hz is written through cfg_we_i / cfg_data_i; the user must write it
// only while the block is idle: the block itself does not enforce this. each item
// runs through one shared 34x17 multiplier: for x, y and heading in turn the
// difference times the rate, then the old filtered rate times its coefficient, then
// the raw rate times its coefficient, then a round and saturate step. before that
// the heading difference is wrapped by a shift and compare-subtract reduction of
// K+2 steps, K = max(ANGLE_WIDTH-22, 0). a new item is accepted only once the
// sequencer has finished the previous one and is back in idle.
// the output register holds the last result; a new item may be accepted while it
// waits, but the next result stays in the block until the receiver drops its stall.
// reset clears the previous pose and the filtered rates to zero and the rate to 100;
// the first item after reset is differenced against a zero pose.
module pose_velocity_estimator
  import pve_pkg::*;
#(
  parameter int POS_WIDTH   = 32,
  parameter int ANGLE_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [POS_WIDTH-1:0]   pos_x_i,
  input  logic signed [POS_WIDTH-1:0]   pos_y_i,
  input  logic signed [ANGLE_WIDTH-1:0] heading_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            vel_x_o,
  output logic signed [31:0]            vel_y_o,
  output logic signed [31:0]            yaw_rate_o
);

  localparam int K      = (ANGLE_WIDTH > 22) ? ANGLE_WIDTH - 22 : 0;
  localparam int UW     = K + 25;
  localparam int UW1    = UW + 1;
  localparam int WSTEPS = K + 2;
  localparam int SW     = $clog2(WSTEPS + 1);
  localparam int DW     = (POS_WIDTH + 1 > MUL_A_W) ? POS_WIDTH + 1 : MUL_A_W;

  localparam logic signed [DW-1:0]  CLAMP_HI = DW'(DIFF_MAX);
  localparam logic signed [DW-1:0]  CLAMP_LO = DW'(DIFF_MIN);
  localparam logic signed [UW1-1:0] WRAP_OFS = UW1'(TWO_PI_Q) << K;
  localparam logic [UW-1:0]         M_INIT   = UW'(TWO_PI_Q) << (K + 1);

  state_e state_q, state_d;

  logic [15:0]                   rate_q;
  logic signed [POS_WIDTH-1:0]   last_x_q;
  logic signed [POS_WIDTH-1:0]   last_y_q;
  logic signed [ANGLE_WIDTH-1:0] last_h_q;
  logic signed [31:0]            filt_q [3];
  logic [1:0]                    ch_q;
  logic [SW-1:0]                 step_q;
  logic                          out_valid_q;

  logic signed [MUL_A_W-1:0] dx_q, dy_q;
  logic [UW-1:0]             r_q, m_q;
  logic signed [PROD_W-1:0]  p_q, acc_q;
  logic signed [31:0]        raw_q;
  logic signed [31:0]        vel_x_q, vel_y_q, yaw_q;

  logic                      in_acc;
  logic                      out_free;
  logic signed [DW-1:0]      dx_full, dy_full;
  logic signed [MUL_A_W-1:0] dx_clamp, dy_clamp;
  logic signed [UW1-1:0]     h_sum;
  logic signed [23:0]        yaw_w;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  yaw_sum;
  logic signed [PROD_W-1:0]  filt_sum;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign vel_x_o     = vel_x_q;
  assign vel_y_o     = vel_y_q;
  assign yaw_rate_o  = yaw_q;

  // position differences, clamped to +-2^32
  assign dx_full  = DW'(pos_x_i) - DW'(last_x_q);
  assign dy_full  = DW'(pos_y_i) - DW'(last_y_q);
  assign dx_clamp = (dx_full > CLAMP_HI) ? DIFF_MAX :
                    (dx_full < CLAMP_LO) ? DIFF_MIN : dx_full[MUL_A_W-1:0];
  assign dy_clamp = (dy_full > CLAMP_HI) ? DIFF_MAX :
                    (dy_full < CLAMP_LO) ? DIFF_MIN : dy_full[MUL_A_W-1:0];

  // heading difference plus pi, offset by a multiple of 2*pi so it is non-negative
  assign h_sum = UW1'(heading_i) - UW1'(last_h_q) + UW1'(PI_Q) + WRAP_OFS;
  assign yaw_w = signed'({1'b0, r_q[22:0]}) - 24'(PI_Q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MRAW: begin
        case (ch_q)
          CH_X:    mul_a = dx_q;
          CH_Y:    mul_a = dy_q;
          default: mul_a = MUL_A_W'(yaw_w);
        endcase
        mul_b = signed'({1'b0, rate_q});
      end
      S_MOLD: begin
        mul_a = MUL_A_W'(filt_q[ch_q]);
        mul_b = COEF_OLD;
      end
      S_MNEW: begin
        mul_a = MUL_A_W'(raw_q);
        mul_b = COEF_RAW;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign yaw_sum  = (p_q + YAW_ROUND) >>> YAW_SHIFT;
  assign filt_sum = (acc_q + p_q) >>> FILT_SHIFT;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_WRAP;
      S_WRAP: if (step_q == SW'(WSTEPS - 1)) state_d = S_MRAW;
      S_MRAW: state_d = S_MOLD;
      S_MOLD: state_d = S_MNEW;
      S_MNEW: state_d = S_ACC;
      S_ACC:  state_d = (ch_q == CH_YAW) ? S_DONE : S_MRAW;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= 16'(RATE_RESET);
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_h_q    <= '0;
      ch_q        <= CH_X;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        filt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rate_q <= cfg_data_i;
      end
      if (in_acc) begin
        last_x_q <= pos_x_i;
        last_y_q <= pos_y_i;
        last_h_q <= heading_i;
        step_q   <= '0;
        ch_q     <= CH_X;
      end
      if (state_q == S_WRAP) begin
        step_q <= step_q + SW'(1);
      end
      if (state_q == S_ACC) begin
        filt_q[ch_q] <= sat32(filt_sum);
        if (ch_q != CH_YAW) begin
          ch_q <= ch_q + 2'd1;
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= dx_clamp;
      dy_q <= dy_clamp;
      r_q  <= h_sum[UW-1:0];
      m_q  <= M_INIT;
    end
    if (state_q == S_WRAP) begin
      if (r_q >= m_q) begin
        r_q <= r_q - m_q;
      end
      m_q <= m_q >> 1;
    end
    if (state_q == S_MRAW || state_q == S_MOLD || state_q == S_MNEW) begin
      p_q <= prod;
    end
    if (state_q == S_MOLD) begin
      raw_q <= (ch_q == CH_YAW) ? sat32(yaw_sum) : sat32(p_q);
    end
    if (state_q == S_MNEW) begin
      acc_q <= p_q + FILT_ROUND;
    end
    if (state_q == S_DONE && out_free) begin
      vel_x_q <= filt_q[CH_X];
      vel_y_q <= filt_q[CH_Y];
      yaw_q   <= filt_q[CH_YAW];
    end
  end

  a_accept_starts_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_WRAP)
    else $error("accepted item did not start the heading wrap");

  a_wrap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRAP && step_q == SW'(WSTEPS - 1)) |=> r_q < UW'(TWO_PI_Q))
    else $error("wrapped heading not below 2*pi");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the done step");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q != 2'd3)
    else $error("channel index out of range");

endmodule
